// ----- hw/rtl/elevator_dispatch_controller_top_macros.svh -----
// Assertion macros of the elevator dispatch controller, used by its top level.
`ifndef ELEVATOR_DISPATCH_CONTROLLER_TOP_MACROS_SVH
`define ELEVATOR_DISPATCH_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTH
`define EDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EDC_ASSERT_SAME(label, ante, cons, msg)
`define EDC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/edc_pkg.sv -----
// Shared types and constants of the elevator dispatch controller.
package edc_pkg;

    localparam int NUM_FLOORS_DEF  = 5;
    localparam int HALL_DEPTH_DEF  = 7;
    localparam int CABIN_DEPTH_DEF = 16;

    // Floor codes are three bits wide for every supported floor count.
    localparam int FLOOR_W  = 3;
    // Cabin weight product: at most 16 riders of an 8-bit weight.
    localparam int WEIGHT_W = 13;

    localparam logic [11:0] MAX_LOAD_RST     = 12'd600;
    localparam logic [7:0]  RIDER_WEIGHT_RST = 8'd70;
    localparam logic [7:0]  FLOOR_PITCH_RST  = 8'd136;
    localparam logic [15:0] IDLE_RETURN_RST  = 16'd333;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_CALL = 1'b1;

    typedef enum logic [1:0] {
        REG_MAX_LOAD     = 2'd0,
        REG_RIDER_WEIGHT = 2'd1,
        REG_FLOOR_PITCH  = 2'd2,
        REG_IDLE_RETURN  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [11:0] max_load;
        logic [7:0]  rider_weight;
        logic [7:0]  floor_pitch;
        logic [15:0] idle_return_ticks;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_CALL,
        OP_IDLE_TICK,
        OP_TICK_START,
        OP_LVL_STEP,
        OP_SRV,
        OP_UNL_STEP,
        OP_UNL_END,
        OP_WANT_RD,
        OP_WANT_CHK,
        OP_DECIDE,
        OP_BRD_RD,
        OP_BRD_CHK,
        OP_BRD_END,
        OP_FIX
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_call;
        logic all_zero;
        logic lvl_hit;
        logic lvl_last;
        logic stop_here;
        logic unl_done;
        logic j_end;
        logic want_flag;
        logic go_serve;
    } t_sts;

endpackage

// ----- hw/rtl/elevator_dispatch_controller_top.sv -----
// Top level of the single-car elevator dispatch controller.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transfer: a time
// tick (i_func low) or a hall call (i_func high) with i_call_floor and i_destination.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per item:
// call acceptance, car position, direction, service flag, cabin load and masks.
// The block works on one item at a time. A hall call passes the decode, call and
// fix states before its result is loaded. A tick with nothing pending passes the
// decode and fix states. A tick that finds work runs a floor-level scan that steps
// one floor a cycle and cabin unloading that steps one rider a cycle, and it visits
// the floor queue memory with a read state and a check state for each entry
// because of its registered read port.
// A finished result sits in the output register; the next item is taken while it
// waits, and its own result waits in the last state until the register is free.
// Synchronous active-low reset empties all queues, parks the car at floor 0
// heading up and restores the configuration registers to their defaults.
// Configuration is an APB-style port with pready tied high.
`include "elevator_dispatch_controller_top_macros.svh"
module elevator_dispatch_controller_top #(
    parameter int NUM_FLOORS  = edc_pkg::NUM_FLOORS_DEF,
    parameter int HALL_DEPTH  = edc_pkg::HALL_DEPTH_DEF,
    parameter int CABIN_DEPTH = edc_pkg::CABIN_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [2:0]            i_call_floor,
    input  logic [2:0]            i_destination,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_call_accepted,
    output logic [2:0]            o_car_floor,
    output logic                  o_going_up,
    output logic                  o_level_at_floor,
    output logic [7:0]            o_car_offset,
    output logic                  o_served_stop,
    output logic [4:0]            o_rider_count,
    output logic [11:0]           o_cabin_weight,
    output logic [NUM_FLOORS-1:0] o_call_mask,
    output logic [NUM_FLOORS-1:0] o_stop_mask
);

    edc_pkg::t_cfg r_cfg;
    edc_pkg::t_cmd cmd;
    edc_pkg::t_sts sts;
    logic          cfg_wr;

    // Writes land on the access phase; the register index sits above the byte offset.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_load          <= edc_pkg::MAX_LOAD_RST;
            r_cfg.rider_weight      <= edc_pkg::RIDER_WEIGHT_RST;
            r_cfg.floor_pitch       <= edc_pkg::FLOOR_PITCH_RST;
            r_cfg.idle_return_ticks <= edc_pkg::IDLE_RETURN_RST;
        end else if (cfg_wr) begin
            unique case (edc_pkg::t_reg_idx'(paddr[3:2]))
                edc_pkg::REG_MAX_LOAD:     r_cfg.max_load          <= pwdata[11:0];
                edc_pkg::REG_RIDER_WEIGHT: r_cfg.rider_weight      <= pwdata[7:0];
                edc_pkg::REG_FLOOR_PITCH:  r_cfg.floor_pitch       <= pwdata[7:0];
                edc_pkg::REG_IDLE_RETURN:  r_cfg.idle_return_ticks <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (edc_pkg::t_reg_idx'(paddr[3:2]))
            edc_pkg::REG_MAX_LOAD:     prdata = 32'(r_cfg.max_load);
            edc_pkg::REG_RIDER_WEIGHT: prdata = 32'(r_cfg.rider_weight);
            edc_pkg::REG_FLOOR_PITCH:  prdata = 32'(r_cfg.floor_pitch);
            edc_pkg::REG_IDLE_RETURN:  prdata = 32'(r_cfg.idle_return_ticks);
            default:                   prdata = '0;
        endcase
    end

    // The sequencer steps through one item and tells the datapath what to do each cycle.
    edc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the car, the floor queues, the cabin list and the result.
    edc_dp #(
        .NUM_FLOORS  (NUM_FLOORS),
        .HALL_DEPTH  (HALL_DEPTH),
        .CABIN_DEPTH (CABIN_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg            (r_cfg),
        .i_func           (i_func),
        .i_call_floor     (i_call_floor),
        .i_destination    (i_destination),
        .o_call_accepted  (o_call_accepted),
        .o_car_floor      (o_car_floor),
        .o_going_up       (o_going_up),
        .o_level_at_floor (o_level_at_floor),
        .o_car_offset     (o_car_offset),
        .o_served_stop    (o_served_stop),
        .o_rider_count    (o_rider_count),
        .o_cabin_weight   (o_cabin_weight),
        .o_call_mask      (o_call_mask),
        .o_stop_mask      (o_stop_mask)
    );

    // Once an item is taken, the block is busy with it on the following cycle.
    `EDC_ASSERT_NEXT(a_busy_after_take, i_in_valid && !o_in_stall, o_in_stall, "idle after take")
    // A hall call never reports a served stop.
    `EDC_ASSERT_SAME(a_call_no_stop, o_out_valid, !(o_served_stop && o_call_accepted), "call+stop")
    // Being level with car_floor means no offset.
    `EDC_ASSERT_SAME(a_level_offset, o_out_valid && o_level_at_floor, o_car_offset == 8'd0, "offset")
    // The cabin never holds more riders than its list.
    `EDC_ASSERT_SAME(a_rider_cap, o_out_valid, int'(o_rider_count) <= CABIN_DEPTH, "riders")

endmodule

// ----- hw/rtl/edc_ram.sv -----
// Generic simple dual-port RAM with a registered read.
module edc_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 35
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/edc_ctrl.sv -----
// Sequencer state machine of the elevator dispatch controller.
module edc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  edc_pkg::t_sts i_sts,
    output edc_pkg::t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DECODE = 14'b00000000000010,
        S_CALL   = 14'b00000000000100,
        S_LVL    = 14'b00000000001000,
        S_SRV    = 14'b00000000010000,
        S_UNL    = 14'b00000000100000,
        S_WRD    = 14'b00000001000000,
        S_WCHK   = 14'b00000010000000,
        S_DECIDE = 14'b00000100000000,
        S_BRD    = 14'b00001000000000,
        S_BCHK   = 14'b00010000000000,
        S_BEND   = 14'b00100000000000,
        S_FIX    = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        n_second     = r_second;
        n_out_valid  = r_out_valid && i_out_stall;
        o_cmd.op       = edc_pkg::OP_NONE;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = edc_pkg::OP_LOAD_IN;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_call) begin
                    n_state = S_CALL;
                end else if (i_sts.all_zero) begin
                    o_cmd.op = edc_pkg::OP_IDLE_TICK;
                    n_state  = S_FIX;
                end else begin
                    o_cmd.op = edc_pkg::OP_TICK_START;
                    n_state  = S_LVL;
                end
            end
            S_CALL: begin
                o_cmd.op = edc_pkg::OP_CALL;
                n_state  = S_FIX;
            end
            S_LVL: begin
                o_cmd.op = edc_pkg::OP_LVL_STEP;
                if (i_sts.lvl_hit) begin
                    n_state = S_SRV;
                end else if (i_sts.lvl_last) begin
                    n_state = S_FIX;
                end
            end
            S_SRV: begin
                o_cmd.op = edc_pkg::OP_SRV;
                n_second = 1'b0;
                n_state  = i_sts.stop_here ? S_UNL : S_WRD;
            end
            S_UNL: begin
                if (i_sts.unl_done) begin
                    o_cmd.op = edc_pkg::OP_UNL_END;
                    n_state  = r_second ? S_BRD : S_WRD;
                end else begin
                    o_cmd.op = edc_pkg::OP_UNL_STEP;
                end
            end
            S_WRD: begin
                if (i_sts.j_end || i_sts.want_flag) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.op = edc_pkg::OP_WANT_RD;
                    n_state  = S_WCHK;
                end
            end
            S_WCHK: begin
                o_cmd.op = edc_pkg::OP_WANT_CHK;
                n_state  = S_WRD;
            end
            S_DECIDE: begin
                o_cmd.op = edc_pkg::OP_DECIDE;
                if (i_sts.go_serve) begin
                    n_second = 1'b1;
                    n_state  = S_UNL;
                end else begin
                    n_state  = S_FIX;
                end
            end
            S_BRD: begin
                if (i_sts.j_end) begin
                    n_state = S_BEND;
                end else begin
                    o_cmd.op = edc_pkg::OP_BRD_RD;
                    n_state  = S_BCHK;
                end
            end
            S_BCHK: begin
                o_cmd.op = edc_pkg::OP_BRD_CHK;
                n_state  = S_BRD;
            end
            S_BEND: begin
                o_cmd.op = edc_pkg::OP_BRD_END;
                n_state  = S_FIX;
            end
            S_FIX: begin
                o_cmd.op = edc_pkg::OP_FIX;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/edc_dp.sv -----
// Datapath of the elevator dispatch controller: car state, queues and result register.
module edc_dp #(
    parameter int NUM_FLOORS  = edc_pkg::NUM_FLOORS_DEF,
    parameter int HALL_DEPTH  = edc_pkg::HALL_DEPTH_DEF,
    parameter int CABIN_DEPTH = edc_pkg::CABIN_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  edc_pkg::t_cmd         i_cmd,
    output edc_pkg::t_sts         o_sts,
    input  edc_pkg::t_cfg         i_cfg,
    input  logic                  i_func,
    input  logic [2:0]            i_call_floor,
    input  logic [2:0]            i_destination,
    output logic                  o_call_accepted,
    output logic [2:0]            o_car_floor,
    output logic                  o_going_up,
    output logic                  o_level_at_floor,
    output logic [7:0]            o_car_offset,
    output logic                  o_served_stop,
    output logic [4:0]            o_rider_count,
    output logic [11:0]           o_cabin_weight,
    output logic [NUM_FLOORS-1:0] o_call_mask,
    output logic [NUM_FLOORS-1:0] o_stop_mask
);

    localparam int FW  = edc_pkg::FLOOR_W;
    localparam int WW  = edc_pkg::WEIGHT_W;
    localparam int FIW = $clog2(NUM_FLOORS);
    localparam int HW  = $clog2((NUM_FLOORS - 1) * 255 + 1);
    localparam int HQD = NUM_FLOORS * HALL_DEPTH;
    localparam int AW  = (HQD > 1) ? $clog2(HQD) : 1;
    localparam int HCW = $clog2(HALL_DEPTH + 1);
    localparam int CCW = $clog2(CABIN_DEPTH + 1);
    localparam int CIW = (CABIN_DEPTH > 1) ? $clog2(CABIN_DEPTH) : 1;

    logic                  r_func, n_func;
    logic [FW-1:0]         r_cf, n_cf;
    logic [FW-1:0]         r_dst, n_dst;
    logic [HCW-1:0]        r_hcount [NUM_FLOORS];
    logic [HCW-1:0]        n_hcount [NUM_FLOORS];
    logic [FW-1:0]         r_cabin [CABIN_DEPTH];
    logic [FW-1:0]         n_cabin [CABIN_DEPTH];
    logic [CCW-1:0]        r_ccount, n_ccount;
    logic [NUM_FLOORS-1:0] r_call, n_call;
    logic [NUM_FLOORS-1:0] r_stop, n_stop;
    logic [FW-1:0]         r_floor, n_floor;
    logic [HW-1:0]         r_height, n_height;
    logic                  r_dir, n_dir;
    logic [15:0]           r_idle, n_idle;
    logic                  r_acc, n_acc;
    logic                  r_served, n_served;
    logic [FW-1:0]         r_lf, n_lf;
    logic [HW-1:0]         r_lacc, n_lacc;
    logic [CCW-1:0]        r_ui, n_ui;
    logic [CCW-1:0]        r_uk, n_uk;
    logic [HCW-1:0]        r_hj, n_hj;
    logic [HCW-1:0]        r_hk, n_hk;
    logic                  r_flag, n_flag;
    logic                  r_was_up, n_was_up;
    logic [HW-1:0]         r_base, n_base;

    logic                  r_o_acc, r_o_dir, r_o_level, r_o_served;
    logic [FW-1:0]         r_o_floor;
    logic [7:0]            r_o_offset;
    logic [4:0]            r_o_count;
    logic [11:0]           r_o_weight;
    logic [NUM_FLOORS-1:0] r_o_call, r_o_stop;

    logic [7:0]            p_eff;
    logic [HW-1:0]         top_h;
    logic [NUM_FLOORS-1:0] all_m, ab_m, be_m;
    logic [FIW-1:0]        fi, cfi;
    logic [HCW-1:0]        hc_cf, hc_call, hall0;
    logic                  call_ok;
    logic [WW-1:0]         weight;
    logic [WW:0]           w_plus;
    logic                  w_over, w_room;
    logic [FW-1:0]         rd_data;
    logic                  way_rd;
    logic                  flag_eff, dec_dir;
    logic [15:0]           idle_inc;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [FW-1:0]         ram_wdata;
    logic [FW-1:0]         cab_ui;
    logic [HW-1:0]         gap;
    logic [WW-1:0]         w_sat;

    function automatic logic [NUM_FLOORS-1:0] f_above(input logic [NUM_FLOORS-1:0] m,
                                                      input logic [FW-1:0] f);
        logic [NUM_FLOORS-1:0] res;
        for (int i = 0; i < NUM_FLOORS; i++) begin
            res[i] = m[i] && (i > int'(f));
        end
        return res;
    endfunction

    function automatic logic [NUM_FLOORS-1:0] f_below(input logic [NUM_FLOORS-1:0] m,
                                                      input logic [FW-1:0] f);
        logic [NUM_FLOORS-1:0] res;
        for (int i = 0; i < NUM_FLOORS; i++) begin
            res[i] = m[i] && (i < int'(f));
        end
        return res;
    endfunction

    function automatic logic [HW-1:0] f_move(input logic [HW-1:0] h, input logic up,
                                             input logic [HW-1:0] top);
        logic [HW-1:0] res;
        res = h;
        if (up) begin
            if (h < top) res = h + 1'b1;
        end else if (h != '0) begin
            res = h - 1'b1;
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [FW-1:0] f, input logic [HCW-1:0] idx);
        return AW'(f) * AW'(HALL_DEPTH) + AW'(idx);
    endfunction

    edc_ram #(
        .WIDTH (FW),
        .DEPTH (HQD)
    ) u_hall_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    always_comb begin
        p_eff    = (i_cfg.floor_pitch == '0) ? 8'd1 : i_cfg.floor_pitch;
        top_h    = HW'(NUM_FLOORS - 1) * HW'(p_eff);
        all_m    = r_call | r_stop;
        ab_m     = f_above(all_m, r_floor);
        be_m     = f_below(all_m, r_floor);
        fi       = r_floor[FIW-1:0];
        cfi      = r_cf[FIW-1:0];
        hc_cf    = r_hcount[fi];
        hc_call  = (int'(r_cf) < NUM_FLOORS) ? r_hcount[cfi] : '0;
        hall0    = (fi == '0) ? r_hk : r_hcount[0];
        call_ok  = (int'(r_cf) < NUM_FLOORS) && (int'(r_dst) < NUM_FLOORS) &&
                   (r_cf != r_dst) && (int'(hc_call) < HALL_DEPTH);
        weight   = WW'(r_ccount) * WW'(i_cfg.rider_weight);
        w_plus   = (WW + 1)'(weight) + (WW + 1)'(i_cfg.rider_weight);
        w_over   = w_plus > (WW + 1)'(i_cfg.max_load);
        w_room   = (w_plus < (WW + 1)'(i_cfg.max_load)) && (int'(r_ccount) < CABIN_DEPTH);
        way_rd   = r_dir ? (rd_data > r_floor) : (rd_data < r_floor);
        flag_eff = r_flag || (r_was_up ? (ab_m == '0) : (be_m == '0));
        dec_dir  = r_flag ? r_dir : (flag_eff ? !r_was_up : r_dir);
        idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
        cab_ui   = r_cabin[r_ui[CIW-1:0]];
        gap      = (r_height >= r_base) ? r_height - r_base : r_base - r_height;
        w_sat    = (weight > WW'(12'hFFF)) ? WW'(12'hFFF) : weight;
    end

    always_comb begin
        o_sts.is_call   = (r_func == edc_pkg::FUNC_CALL);
        o_sts.all_zero  = (all_m == '0);
        o_sts.lvl_hit   = (r_lacc == r_height);
        o_sts.lvl_last  = (int'(r_lf) == NUM_FLOORS - 1);
        o_sts.stop_here = r_stop[fi];
        o_sts.unl_done  = (r_ui == r_ccount);
        o_sts.j_end     = (r_hj >= hc_cf);
        o_sts.want_flag = r_flag;
        o_sts.go_serve  = !w_over && flag_eff;
    end

    always_comb begin
        n_func   = r_func;
        n_cf     = r_cf;
        n_dst    = r_dst;
        n_hcount = r_hcount;
        n_cabin  = r_cabin;
        n_ccount = r_ccount;
        n_call   = r_call;
        n_stop   = r_stop;
        n_floor  = r_floor;
        n_height = r_height;
        n_dir    = r_dir;
        n_idle   = r_idle;
        n_acc    = r_acc;
        n_served = r_served;
        n_lf     = r_lf;
        n_lacc   = r_lacc;
        n_ui     = r_ui;
        n_uk     = r_uk;
        n_hj     = r_hj;
        n_hk     = r_hk;
        n_flag   = r_flag;
        n_was_up = r_was_up;
        n_base   = r_base;
        ram_we    = 1'b0;
        ram_waddr = f_addr(r_floor, r_hk);
        ram_wdata = rd_data;
        ram_raddr = f_addr(r_floor, r_hj);
        unique case (i_cmd.op)
            edc_pkg::OP_NONE: begin
            end
            edc_pkg::OP_LOAD_IN: begin
                n_func   = i_func;
                n_cf     = i_call_floor;
                n_dst    = i_destination;
                n_acc    = 1'b0;
                n_served = 1'b0;
            end
            edc_pkg::OP_CALL: begin
                if (call_ok) begin
                    ram_we        = 1'b1;
                    ram_waddr     = f_addr(r_cf, hc_call);
                    ram_wdata     = r_dst;
                    n_hcount[cfi] = hc_call + 1'b1;
                    if (all_m == '0) n_dir = (r_floor < r_cf);
                    n_call[cfi]   = 1'b1;
                    n_acc         = 1'b1;
                end
            end
            edc_pkg::OP_IDLE_TICK: begin
                n_idle = idle_inc;
                if (idle_inc == i_cfg.idle_return_ticks) n_stop[0] = 1'b1;
            end
            edc_pkg::OP_TICK_START: begin
                n_idle = '0;
                if (r_dir) begin
                    if (ab_m == '0 && be_m != '0) n_dir = 1'b0;
                end else if (be_m == '0 && ab_m != '0) begin
                    n_dir = 1'b1;
                end
                n_lf   = '0;
                n_lacc = '0;
            end
            edc_pkg::OP_LVL_STEP: begin
                if (r_lacc == r_height) begin
                    n_floor = r_lf;
                end else if (int'(r_lf) == NUM_FLOORS - 1) begin
                    n_height = f_move(r_height, r_dir, top_h);
                end else begin
                    n_lf   = r_lf + 1'b1;
                    n_lacc = r_lacc + HW'(p_eff);
                end
            end
            edc_pkg::OP_SRV: begin
                n_was_up   = r_dir;
                n_stop[fi] = 1'b0;
                n_ui       = '0;
                n_uk       = '0;
                n_hj       = '0;
                n_flag     = 1'b0;
            end
            edc_pkg::OP_UNL_STEP: begin
                if (cab_ui != r_floor) begin
                    n_cabin[r_uk[CIW-1:0]] = cab_ui;
                    n_uk = r_uk + 1'b1;
                end
                n_ui = r_ui + 1'b1;
            end
            edc_pkg::OP_UNL_END: begin
                n_ccount = r_uk;
                n_hj     = '0;
                n_hk     = '0;
            end
            edc_pkg::OP_WANT_RD: begin
            end
            edc_pkg::OP_WANT_CHK: begin
                if (way_rd) n_flag = 1'b1;
                n_hj = r_hj + 1'b1;
            end
            edc_pkg::OP_DECIDE: begin
                n_dir = dec_dir;
                if (w_over || !flag_eff) n_height = f_move(r_height, dec_dir, top_h);
                n_ui  = '0;
                n_uk  = '0;
            end
            edc_pkg::OP_BRD_RD: begin
            end
            edc_pkg::OP_BRD_CHK: begin
                if (way_rd && w_room) begin
                    for (int i = 0; i < NUM_FLOORS; i++) begin
                        if (int'(rd_data) == i) n_stop[i] = 1'b1;
                    end
                    n_cabin[r_ccount[CIW-1:0]] = rd_data;
                    n_ccount = r_ccount + 1'b1;
                end else begin
                    ram_we = 1'b1;
                    n_hk   = r_hk + 1'b1;
                end
                n_hj = r_hj + 1'b1;
            end
            edc_pkg::OP_BRD_END: begin
                n_hcount[fi] = r_hk;
                if (r_hk == '0) n_call[fi] = 1'b0;
                if (!r_was_up && r_stop[0] && hall0 == '0 && r_ccount == '0) n_stop[0] = 1'b0;
                n_served = 1'b1;
            end
            edc_pkg::OP_FIX: begin
                if (r_func == edc_pkg::FUNC_TICK) begin
                    if (r_floor == '0) begin
                        n_dir = 1'b1;
                    end else if (int'(r_floor) == NUM_FLOORS - 1) begin
                        n_dir = 1'b0;
                    end
                end
                n_base = HW'(r_floor) * HW'(p_eff);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FLOORS; i++) r_hcount[i] <= '0;
            r_ccount <= '0;
            r_call   <= '0;
            r_stop   <= '0;
            r_floor  <= '0;
            r_height <= '0;
            r_dir    <= 1'b1;
            r_idle   <= '0;
        end else begin
            r_hcount <= n_hcount;
            r_ccount <= n_ccount;
            r_call   <= n_call;
            r_stop   <= n_stop;
            r_floor  <= n_floor;
            r_height <= n_height;
            r_dir    <= n_dir;
            r_idle   <= n_idle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_cf     <= n_cf;
        r_dst    <= n_dst;
        r_cabin  <= n_cabin;
        r_acc    <= n_acc;
        r_served <= n_served;
        r_lf     <= n_lf;
        r_lacc   <= n_lacc;
        r_ui     <= n_ui;
        r_uk     <= n_uk;
        r_hj     <= n_hj;
        r_hk     <= n_hk;
        r_flag   <= n_flag;
        r_was_up <= n_was_up;
        r_base   <= n_base;
        if (i_cmd.load_out) begin
            r_o_acc    <= r_acc;
            r_o_floor  <= r_floor;
            r_o_dir    <= r_dir;
            r_o_level  <= (r_height == r_base);
            r_o_offset <= (gap > HW'(255)) ? 8'hFF : gap[7:0];
            r_o_served <= r_served;
            r_o_count  <= 5'(r_ccount);
            r_o_weight <= w_sat[11:0];
            r_o_call   <= r_call;
            r_o_stop   <= r_stop;
        end
    end

    assign o_call_accepted  = r_o_acc;
    assign o_car_floor      = r_o_floor;
    assign o_going_up       = r_o_dir;
    assign o_level_at_floor = r_o_level;
    assign o_car_offset     = r_o_offset;
    assign o_served_stop    = r_o_served;
    assign o_rider_count    = r_o_count;
    assign o_cabin_weight   = r_o_weight;
    assign o_call_mask      = r_o_call;
    assign o_stop_mask      = r_o_stop;

endmodule
